// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RNC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define RNC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/rnc_pkg.sv -----
// ----------------------------------------------------------------------------
// rnc_pkg
// Types, constants and helpers for the radix number converter.
// ----------------------------------------------------------------------------
package rnc_pkg;

	localparam int CHAR_W            = 8;
	localparam int RADIX_W           = 6;
	localparam int MAX_OUT_CHARS_DEF = 7;
	localparam int VALUE_WIDTH_DEF   = 32;

	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h41;
	localparam logic [CHAR_W-1:0]  CHAR_Z     = 8'h5A;
	localparam logic [CHAR_W-1:0]  CHAR_NUL   = 8'h00;
	localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;

	// divider status towards the sequencer
	typedef struct packed {
		logic               done;
		logic [RADIX_W-1:0] rem;
	} rnc_div_sts_t;

	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] r;
		if (d < DIGIT_TEN) begin
			r = CHAR_ZERO + {2'b00, d};
		end else begin
			r = CHAR_A + {2'b00, d - DIGIT_TEN};
		end
		return r;
	endfunction

endpackage

// ----- rtl/radix_number_converter_top.sv -----
// ----------------------------------------------------------------------------
// radix_number_converter_top
// Rebuilds a signed number from its characters and writes it in a new radix.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle until the item marked last.
// After the last item the number is prepared, then each output digit goes
// through the shared bit-serial divider, then one result item per cycle
// while the output is not stalled.
// Reset (arst_n low, asynchronous) clears the number state and output valid.
module radix_number_converter_top import rnc_pkg::*; #(
	parameter int MAX_OUT_CHARS = MAX_OUT_CHARS_DEF,
	parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // in_char[7:0], src_radix[13:8], dst_radix[19:14]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // out_char[7:0]
	output logic        m_axis_tuser,  // too_long[0]
	output logic        m_axis_tlast
);

	localparam int CW = $clog2(MAX_OUT_CHARS + 1);
	localparam int IW = (MAX_OUT_CHARS > 1) ? $clog2(MAX_OUT_CHARS) : 1;
	localparam int W  = VALUE_WIDTH;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PREP  = 5'b00010,
		ST_START = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [W-1:0]       acc_q;
	logic               minus_q;
	logic               first_q;
	logic [RADIX_W-1:0] drad_q;
	logic [W-1:0]       mag_q;
	logic               neg_q;
	logic               sign_pend_q;
	logic               err_q;
	logic [CW-1:0]      cnt_q;
	logic [RADIX_W-1:0] buf_q [MAX_OUT_CHARS];

	logic               m_valid_q;
	logic [CHAR_W-1:0]  m_data_q;
	logic               m_user_q;
	logic               m_last_q;

	logic [CHAR_W-1:0]  in_char;
	logic [RADIX_W-1:0] src_radix;
	logic [RADIX_W-1:0] dst_radix;
	logic               accept;
	logic               is_minus;
	logic [W-1:0]       digit;
	logic [W-1:0]       acc_next;
	logic [W-1:0]       val;
	logic [W-1:0]       mag;
	logic [RADIX_W-1:0] drad_clamp;
	logic               out_free;
	logic [CW:0]        total;
	logic               div_start;
	logic [W-1:0]       div_quo;
	rnc_div_sts_t       div_sts;

	assign in_char   = s_axis_tdata[7:0];
	assign src_radix = s_axis_tdata[13:8];
	assign dst_radix = s_axis_tdata[19:14];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_minus      = first_q && (in_char == CHAR_MINUS);

	// digit value wraps: characters below '0' give a negative digit
	assign digit    = (in_char >= CHAR_A) ? W'(in_char) - W'(CHAR_A) + W'(DIGIT_TEN)
	                                      : W'(in_char) - W'(CHAR_ZERO);
	assign acc_next = acc_q * {{(W-RADIX_W){1'b0}}, src_radix} + digit;

	assign drad_clamp = (dst_radix < RADIX_MIN) ? RADIX_MIN :
	                    (dst_radix > RADIX_MAX) ? RADIX_MAX : dst_radix;

	assign val = minus_q ? (W'(0) - acc_q) : acc_q;
	assign mag = val[W-1] ? (W'(0) - val) : val;

	assign total     = {1'b0, cnt_q} + (CW+1)'(1) + {{CW{1'b0}}, neg_q};
	assign div_start = (state_q == ST_START);
	assign out_free  = !m_valid_q || m_axis_tready;

	rnc_divider #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (drad_q),
		.quotient (div_quo),
		.sts      (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			minus_q     <= 1'b0;
			first_q     <= 1'b1;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			sign_pend_q <= 1'b0;
			err_q       <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (out_free) begin
				m_valid_q <= (state_q == ST_EMIT);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_minus) begin
							minus_q <= 1'b1;
						end else begin
							acc_q <= acc_next;
						end
						first_q <= 1'b0;
						if (s_axis_tlast) begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					neg_q       <= val[W-1];
					sign_pend_q <= val[W-1];
					err_q       <= 1'b0;
					cnt_q       <= '0;
					acc_q       <= '0;
					minus_q     <= 1'b0;
					first_q     <= 1'b1;
					state_q     <= ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_sts.done) begin
						cnt_q <= cnt_q + 1'b1;
						// further digits only make the text longer
						if (total > (CW+1)'(MAX_OUT_CHARS)) begin
							err_q   <= 1'b1;
							state_q <= ST_EMIT;
						end else if (div_quo == '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_START;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (err_q) begin
							state_q <= ST_IDLE;
						end else if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q - 1'b1;
							if (cnt_q == CW'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: buffer, divisor, dividend and output data
	always_ff @(posedge clk) begin
		if (accept && s_axis_tlast) begin
			drad_q <= drad_clamp;
		end
		if (state_q == ST_PREP) begin
			mag_q <= mag;
		end
		if ((state_q == ST_DIV) && div_sts.done) begin
			mag_q <= div_quo;
			if (cnt_q < CW'(MAX_OUT_CHARS)) begin
				buf_q[cnt_q[IW-1:0]] <= div_sts.rem;
			end
		end
		if ((state_q == ST_EMIT) && out_free) begin
			if (err_q) begin
				m_data_q <= CHAR_NUL;
				m_user_q <= 1'b1;
				m_last_q <= 1'b1;
			end else if (sign_pend_q) begin
				m_data_q <= CHAR_MINUS;
				m_user_q <= 1'b0;
				m_last_q <= 1'b0;
			end else begin
				m_data_q <= digit_glyph(buf_q[IW'(cnt_q - 1'b1)]);
				m_user_q <= 1'b0;
				m_last_q <= (cnt_q == CW'(1));
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

endmodule

// ----- rtl/rnc_divider.sv -----
// ----------------------------------------------------------------------------
// rnc_divider
// Restoring divider: one quotient bit per cycle, radix-sized divisor.
// ----------------------------------------------------------------------------
module rnc_divider import rnc_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [RADIX_W-1:0]     divisor,
	output logic [VALUE_WIDTH-1:0] quotient,
	output rnc_div_sts_t           sts
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [RADIX_W-1:0]     rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [RADIX_W:0]       trial;
	logic [RADIX_W:0]       diff;
	logic                   ge;

	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(VALUE_WIDTH);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// remainder stays below the divisor, so six bits hold it
			rem_q <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign sts.done = done_q;
	assign sts.rem  = rem_q;

endmodule

// ----- rtl/rnc_checker.sv -----
// ----------------------------------------------------------------------------
// rnc_checker
// Port-level checks for the radix number converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rnc_checker import rnc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	logic in_acc;
	logic stall;
	logic glyph_ok;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign stall    = m_axis_tvalid && !m_axis_tready;
	assign glyph_ok = (m_axis_tdata == CHAR_MINUS) ||
	                  ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_NINE)) ||
	                  ((m_axis_tdata >= CHAR_A) && (m_axis_tdata <= CHAR_Z));

	`RNC_ASSERT_NXT(a_out_hold, stall, m_axis_tvalid && $stable(m_axis_tdata))
	`RNC_ASSERT_IMP(a_err_item, m_axis_tvalid && m_axis_tuser, (m_axis_tdata == CHAR_NUL) && m_axis_tlast)
	`RNC_ASSERT_IMP(a_glyph, m_axis_tvalid && !m_axis_tuser, glyph_ok)
	`RNC_ASSERT_NXT(a_busy_after_last, in_acc && s_axis_tlast, !s_axis_tready)

endmodule

bind radix_number_converter_top rnc_checker u_rnc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- tb/rnc_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rnc_result_checker
// Watches the character stream in and the result stream out of the radix
// converter. Rebuilds each number itself, works out the text it should come
// out as, and compares every result item with the oldest one still awaited.
// ----------------------------------------------------------------------------
module rnc_result_checker import rnc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // in_char[7:0], src_radix[13:8], dst_radix[19:14]
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,  // out_char[7:0]
	input  logic        m_axis_tuser,  // too_long[0]
	input  logic        m_axis_tlast,
	output int          pending,
	output int          fail_count
);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              too_long;
		logic              last;
	} out_item_t;

	string glyph_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

	out_item_t                  expected_chars[$];
	logic [VALUE_WIDTH_DEF-1:0] acc_value;
	logic                       minus_flag;
	logic                       at_first_char;

	// fold one character into the number; on the last one queue its text
	task automatic take_char(input logic [CHAR_W-1:0] ch, input logic [RADIX_W-1:0] srad,
			input logic [RADIX_W-1:0] drad, input logic last);
		logic [VALUE_WIDTH_DEF-1:0] digit, value, mag;
		logic [RADIX_W-1:0]         base;
		logic [RADIX_W-1:0]         digs [0:VALUE_WIDTH_DEF];
		logic                       neg;
		int                         n, k;
		if (at_first_char && ch == CHAR_MINUS) begin
			minus_flag = 1'b1;
		end else begin
			// characters below '0' give a negative digit, absorbed by the wrap
			if (ch >= CHAR_A)
				digit = VALUE_WIDTH_DEF'(ch) - VALUE_WIDTH_DEF'(CHAR_A) + VALUE_WIDTH_DEF'(DIGIT_TEN);
			else
				digit = VALUE_WIDTH_DEF'(ch) - VALUE_WIDTH_DEF'(CHAR_ZERO);
			acc_value = acc_value * VALUE_WIDTH_DEF'(srad) + digit;
		end
		at_first_char = 1'b0;
		if (!last)
			return;

		value         = minus_flag ? -acc_value : acc_value;
		acc_value     = '0;
		minus_flag    = 1'b0;
		at_first_char = 1'b1;

		base = (drad < RADIX_MIN) ? RADIX_MIN : (drad > RADIX_MAX) ? RADIX_MAX : drad;
		neg  = value[VALUE_WIDTH_DEF-1];
		mag  = neg ? -value : value;
		n    = 0;
		do begin
			digs[n] = RADIX_W'(mag % VALUE_WIDTH_DEF'(base));
			mag     = mag / VALUE_WIDTH_DEF'(base);
			n++;
		end while (mag != 0);

		if (n + int'(neg) > MAX_OUT_CHARS_DEF) begin
			expected_chars.push_back({CHAR_NUL, 1'b1, 1'b1});
		end else begin
			if (neg)
				expected_chars.push_back({CHAR_MINUS, 1'b0, 1'b0});
			for (k = n - 1; k >= 0; k--)
				expected_chars.push_back({CHAR_W'(glyph_set[digs[k]]), 1'b0, k == 0});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			acc_value     = '0;
			minus_flag    = 1'b0;
			at_first_char = 1'b1;
			expected_chars.delete();
			pending       = 0;
			fail_count    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected result item: out_char %h too_long %b out_last %b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (m_axis_tdata !== want.ch) begin
						$error("out_char: expected %h, got %h", want.ch, m_axis_tdata);
						fail_count++;
					end
					if (m_axis_tuser !== want.too_long) begin
						$error("too_long: expected %b, got %b", want.too_long, m_axis_tuser);
						fail_count++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("out_last: expected %b, got %b", want.last, m_axis_tlast);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_char(s_axis_tdata[7:0], s_axis_tdata[13:8], s_axis_tdata[19:14],
					s_axis_tlast);
			pending = expected_chars.size();
		end
	end

endmodule

// ----- tb/radix_number_converter_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_number_converter_top_test
// Feeds the radix converter directed corner numbers and then random numbers,
// mostly well formed with some noise, with random gaps on both streams, a
// long output stall and drain pauses. Checking is left to the checker.
// ----------------------------------------------------------------------------
module radix_number_converter_top_test import rnc_pkg::*; ();

	localparam int RANDOM_ITEMS = 140;
	localparam int IDLE_LIMIT   = 6000;
	localparam int TAIL_CYCLES  = 200;
	localparam int LONG_HOLD    = 400;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	int    pending;
	int    fail_count;
	int    sent_items = 0;
	int    tx_quiet   = 0;
	int    rx_quiet   = 0;
	int    idle_cycles;
	bit    long_hold  = 1'b0;
	string glyph_set  = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

	radix_number_converter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	rnc_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.pending       (pending),
		.fail_count    (fail_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// gap before the next item, with occasional stretches of none at all
	function automatic int pick_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic [5:0] srad,
			input logic [5:0] drad, input logic last);
		int gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, drad, srad, ch};
		s_axis_tlast  <= last;
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		sent_items++;
	endtask

	task automatic send_text(input string txt, input logic [5:0] srad, input logic [5:0] drad);
		int i;
		for (i = 0; i < txt.len(); i++)
			send_char(txt[i], srad, drad, i == txt.len() - 1);
	endtask

	// hold the input until every awaited result has come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_random_number();
		int         kind, len, i, d;
		logic [5:0] srad, drad;
		logic [7:0] ch;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// noise: any character, any radix code
			len  = $urandom_range(1, 4);
			srad = 6'($urandom_range(0, 63));
			drad = 6'($urandom_range(0, 63));
			for (i = 0; i < len; i++)
				send_char(8'($urandom_range(0, 255)), srad, drad, i == len - 1);
		end else begin
			srad = 6'($urandom_range(2, 36));
			drad = (kind == 2) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(2, 36));
			len  = $urandom_range(1, 7);
			if ($urandom_range(0, 3) == 0)
				send_char(CHAR_MINUS, srad, drad, 1'b0);
			for (i = 0; i < len; i++) begin
				d  = $urandom_range(0, srad - 1);
				ch = glyph_set[d];
				// broken number: a stray minus or a random letter, which may lie outside the radix
				if (kind == 1 && i == len / 2)
					ch = $urandom_range(0, 1) ? CHAR_MINUS : 8'($urandom_range(CHAR_A, CHAR_Z));
				send_char(ch, srad, drad, i == len - 1);
			end
		end
	endtask

	initial begin : sink
		int w;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			w         = long_hold ? LONG_HOLD : pick_gap(rx_quiet);
			long_hold = 1'b0;
			if (w > 0) begin
				m_axis_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(negedge clk);
			while (!m_axis_tvalid) @(negedge clk);
			@(posedge clk);
		end
	end

	// end the run if nothing moves on either stream for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("radix_number_converter_top_test: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int i, base_items;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("0", 6'd10, 6'd2);
		send_text("-", 6'd10, 6'd10);
		send_text("-80000000", 6'd16, 6'd36);   // most negative value
		send_text("ZZZZZZZ", 6'd36, 6'd2);      // far too long in binary
		send_text("1-", 6'd10, 6'd10);          // minus after the first character
		send_char(8'hFF, 6'd63, 6'd63, 1'b1);
		send_char("1", 6'd0, 6'd0, 1'b1);
		send_char(8'h00, 6'd0, 6'd10, 1'b1);
		drain();

		// stall the output for a long stretch while numbers keep coming
		base_items = sent_items;
		long_hold  = 1'b1;
		tx_quiet   = 60;
		for (i = 0; i < 4; i++)
			send_text("98765", 6'd10, 6'd10);
		drain();

		i = 0;
		while (sent_items < base_items + RANDOM_ITEMS) begin
			i++;
			if (i % 9 == 0)
				drain();
			send_random_number();
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("radix_number_converter_top_test: PASS");
		end else begin
			$display("radix_number_converter_top_test: FAIL");
		end
		$finish;
	end

endmodule
